/* rtl/dxtf_pkg.sv */
`timescale 1ns / 1ps

package dxtf_pkg;

    // sizes fixed by the field widths
    localparam int SIDE_W   = 15;
    localparam int LEVEL_W  = 4;
    localparam int INDEX_W  = 29;
    localparam int FMT_W    = 3;
    localparam int CFG_IDX_W = 2;

    localparam int DEF_MAX_SIDE   = 16384;
    localparam int DEF_MAX_LEVELS = 15;

    // pixel format codes, six and seven behave as two-byte pixels
    localparam logic [FMT_W-1:0] FMT_DXT1  = 3'd0;
    localparam logic [FMT_W-1:0] FMT_DXT3  = 3'd1;
    localparam logic [FMT_W-1:0] FMT_DXT5  = 3'd2;
    localparam logic [FMT_W-1:0] FMT_PIX32 = 3'd3;
    localparam logic [FMT_W-1:0] FMT_PIX24 = 3'd4;
    localparam logic [FMT_W-1:0] FMT_PIX16 = 3'd5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVELS = 2'd3;

    typedef enum logic [1:0] {
        ROW_KEEP    = 2'd0,
        ROW_REVERSE = 2'd1,
        ROW_SWAP    = 2'd2
    } row_mode_t;

    typedef struct packed {
        logic [63:0] unit_low;
        logic [63:0] unit_high;
    } in_item_t;

    typedef struct packed {
        logic [INDEX_W-1:0] dest_index;
        logic [63:0]        flipped_low;
        logic [63:0]        flipped_high;
        logic               chain_end;
    } out_item_t;

    // where one unit sits in the chain, taken at acceptance
    typedef struct packed {
        logic [FMT_W-1:0]   fmt;
        row_mode_t          mode;
        logic [SIDE_W-1:0]  rrow;
        logic [SIDE_W-1:0]  across;
        logic [SIDE_W-1:0]  col;
        logic [INDEX_W-1:0] level_start;
        logic               last;
    } unit_pos_t;

endpackage

/* rtl/dxtf_walk.sv */
`timescale 1ns / 1ps

module dxtf_walk
    import dxtf_pkg::*;
#(
    parameter int MAX_SIDE   = DEF_MAX_SIDE,
    parameter int MAX_LEVELS = DEF_MAX_LEVELS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIDE_W-1:0]    cfg_data,
    input  logic                 advance,
    output unit_pos_t            pos
);

    logic [FMT_W-1:0]   fmt_reg, fmt_next;
    logic [SIDE_W-1:0]  base_w_reg, base_w_next;
    logic [SIDE_W-1:0]  base_h_reg, base_h_next;
    logic [LEVEL_W-1:0] mips_reg, mips_next;

    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [SIDE_W-1:0]  lw_reg, lw_next;
    logic [SIDE_W-1:0]  lh_reg, lh_next;
    logic [SIDE_W-1:0]  row_reg, row_next;
    logic [SIDE_W-1:0]  col_reg, col_next;
    logic [INDEX_W-1:0] start_reg, start_next;
    logic [INDEX_W-1:0] units_reg, units_next;

    logic               dxt;
    logic [SIDE_W:0]    w_plus, h_plus;
    logic [SIDE_W-1:0]  across, rows;
    logic [LEVEL_W-1:0] levels;
    logic [LEVEL_W:0]   level_inc;
    logic               col_end, row_end, chain_done;
    row_mode_t          mode;

    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] r;
        r = v;
        if (v == '0)
            r = SIDE_W'(1);
        else if (v > SIDE_W'(MAX_SIDE))
            r = SIDE_W'(MAX_SIDE);
        return r;
    endfunction

    function automatic logic [SIDE_W-1:0] halve(input logic [SIDE_W-1:0] v);
        return (v > SIDE_W'(1)) ? (v >> 1) : SIDE_W'(1);
    endfunction

    assign dxt    = (fmt_reg == FMT_DXT1) || (fmt_reg == FMT_DXT3) || (fmt_reg == FMT_DXT5);
    assign w_plus = {1'b0, lw_reg} + (SIDE_W+1)'(3);
    assign h_plus = {1'b0, lh_reg} + (SIDE_W+1)'(3);
    assign across = dxt ? {1'b0, w_plus[SIDE_W:2]} : lw_reg;
    assign rows   = dxt ? {1'b0, h_plus[SIDE_W:2]} : lh_reg;

    always_comb
    begin
        if (mips_reg == '0)
            levels = LEVEL_W'(1);
        else if (mips_reg > LEVEL_W'(MAX_LEVELS))
            levels = LEVEL_W'(MAX_LEVELS);
        else
            levels = mips_reg;
    end

    always_comb
    begin
        if (lh_reg >= SIDE_W'(4))
            mode = ROW_REVERSE;
        else if (lh_reg == SIDE_W'(2))
            mode = ROW_SWAP;
        else
            mode = ROW_KEEP;
    end

    assign level_inc  = {1'b0, level_reg} + (LEVEL_W+1)'(1);
    assign col_end    = (col_reg + SIDE_W'(1)) == across;
    assign row_end    = (row_reg + SIDE_W'(1)) == rows;
    assign chain_done = level_inc >= {1'b0, levels};

    assign pos.fmt         = fmt_reg;
    assign pos.mode        = mode;
    assign pos.rrow        = rows - SIDE_W'(1) - row_reg;
    assign pos.across      = across;
    assign pos.col         = col_reg;
    assign pos.level_start = start_reg;
    assign pos.last        = chain_done && row_end && col_end;

    always_comb
    begin
        fmt_next    = fmt_reg;
        base_w_next = base_w_reg;
        base_h_next = base_h_reg;
        mips_next   = mips_reg;
        level_next  = level_reg;
        lw_next     = lw_reg;
        lh_next     = lh_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        start_next  = start_reg;
        units_next  = units_reg;

        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_FORMAT: fmt_next    = cfg_data[FMT_W-1:0];
                CFG_WIDTH:  base_w_next = cfg_data;
                CFG_HEIGHT: base_h_next = cfg_data;
                CFG_LEVELS: mips_next   = cfg_data[LEVEL_W-1:0];
                default:    fmt_next    = fmt_reg;
            endcase
            // any write restarts the walk on the new base size
            level_next = '0;
            lw_next    = clamp_side(base_w_next);
            lh_next    = clamp_side(base_h_next);
            row_next   = '0;
            col_next   = '0;
            start_next = '0;
            units_next = '0;
        end
        else if (advance)
        begin
            units_next = units_reg + INDEX_W'(1);
            col_next   = col_reg + SIDE_W'(1);
            if (col_end)
            begin
                col_next = '0;
                row_next = row_reg + SIDE_W'(1);
                if (row_end)
                begin
                    row_next   = '0;
                    level_next = level_inc[LEVEL_W-1:0];
                    start_next = units_next;
                    lw_next    = halve(lw_reg);
                    lh_next    = halve(lh_reg);
                    if (chain_done)
                    begin
                        level_next = '0;
                        lw_next    = clamp_side(base_w_reg);
                        lh_next    = clamp_side(base_h_reg);
                        start_next = '0;
                        units_next = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg    <= FMT_DXT1;
            base_w_reg <= SIDE_W'(1);
            base_h_reg <= SIDE_W'(1);
            mips_reg   <= LEVEL_W'(1);
            level_reg  <= '0;
            lw_reg     <= SIDE_W'(1);
            lh_reg     <= SIDE_W'(1);
            row_reg    <= '0;
            col_reg    <= '0;
            start_reg  <= '0;
            units_reg  <= '0;
        end
        else
        begin
            fmt_reg    <= fmt_next;
            base_w_reg <= base_w_next;
            base_h_reg <= base_h_next;
            mips_reg   <= mips_next;
            level_reg  <= level_next;
            lw_reg     <= lw_next;
            lh_reg     <= lh_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            start_reg  <= start_next;
            units_reg  <= units_next;
        end
    end

    // the walk never leaves the current level's grid
    a_col_in_level: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg < across)
        else $error("column count outside level");

    a_row_in_level: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg < rows)
        else $error("row count outside level");

endmodule

/* rtl/dxtf_out.sv */
`timescale 1ns / 1ps

module dxtf_out
    import dxtf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      stage_valid,
    input  in_item_t  stage_item,
    input  unit_pos_t stage_pos,
    output logic      take,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_item
);

    logic        out_valid_reg;
    out_item_t   out_item_reg, out_item_next;
    logic [2*SIDE_W-1:0] row_offset;
    logic [63:0] lo, hi;

    // four 8-bit rows in a 32-bit word
    function automatic logic [31:0] flip8(input logic [31:0] v, input row_mode_t m);
        logic [31:0] r;
        case (m)
            ROW_REVERSE: r = {v[7:0], v[15:8], v[23:16], v[31:24]};
            ROW_SWAP:    r = {v[31:16], v[7:0], v[15:8]};
            default:     r = v;
        endcase
        return r;
    endfunction

    function automatic logic [63:0] flip16(input logic [63:0] v, input row_mode_t m);
        logic [63:0] r;
        case (m)
            ROW_REVERSE: r = {v[15:0], v[31:16], v[47:32], v[63:48]};
            ROW_SWAP:    r = {v[63:32], v[15:0], v[31:16]};
            default:     r = v;
        endcase
        return r;
    endfunction

    function automatic logic [47:0] flip12(input logic [47:0] v, input row_mode_t m);
        logic [47:0] r;
        case (m)
            ROW_REVERSE: r = {v[11:0], v[23:12], v[35:24], v[47:36]};
            ROW_SWAP:    r = {v[47:24], v[11:0], v[23:12]};
            default:     r = v;
        endcase
        return r;
    endfunction

    assign lo = stage_item.unit_low;
    assign hi = stage_item.unit_high;

    assign row_offset = (2*SIDE_W)'(stage_pos.rrow) * (2*SIDE_W)'(stage_pos.across);

    always_comb
    begin
        out_item_next.dest_index   = stage_pos.level_start + row_offset[INDEX_W-1:0]
                                     + INDEX_W'(stage_pos.col);
        out_item_next.chain_end    = stage_pos.last;
        out_item_next.flipped_high = '0;
        case (stage_pos.fmt)
            FMT_DXT1:
                out_item_next.flipped_low = {flip8(lo[63:32], stage_pos.mode), lo[31:0]};
            FMT_DXT3:
            begin
                out_item_next.flipped_low  = flip16(lo, stage_pos.mode);
                out_item_next.flipped_high = {flip8(hi[63:32], stage_pos.mode), hi[31:0]};
            end
            FMT_DXT5:
            begin
                out_item_next.flipped_low  = {flip12(lo[63:16], stage_pos.mode), lo[15:0]};
                out_item_next.flipped_high = {flip8(hi[63:32], stage_pos.mode), hi[31:0]};
            end
            FMT_PIX32: out_item_next.flipped_low = {32'd0, lo[31:0]};
            FMT_PIX24: out_item_next.flipped_low = {40'd0, lo[23:0]};
            default:   out_item_next.flipped_low = {48'd0, lo[15:0]};
        endcase
    end

    // output register frees up when empty or being taken
    assign take = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (take)
            out_valid_reg <= stage_valid;
    end

    always_ff @(posedge clk)
    begin
        if (take && stage_valid)
            out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    a_pixel_high_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (take && stage_valid && stage_pos.fmt != FMT_DXT3 && stage_pos.fmt != FMT_DXT5)
        |=> out_item_reg.flipped_high == '0)
        else $error("upper half not cleared");

endmodule

/* rtl/dxt_mip_chain_vertical_flip_top.sv */
`timescale 1ns / 1ps

// channel | direction | handshake            | payload
// in      | input     | in_valid / in_stall  | in_item (unit_low, unit_high)
// out     | output    | out_valid / out_stall| out_item (dest_index, flipped_*, chain_end)
// cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one item per cycle sustained while out_stall is low; an accepted item passes through
// the input stage register, then the result register holding the multiply-add and row permutation
// the mip walk counters advance at acceptance, so no loop limits the rate
// rst_n clears valids, config registers and the walk; payload registers are not reset
// in_stall rises only when both stages are full and out_stall is high
// cfg_ready is always high; any write restarts the walk at the top level

module dxt_mip_chain_vertical_flip_top
    import dxtf_pkg::*;
#(
    parameter int MAX_SIDE   = DEF_MAX_SIDE,
    parameter int MAX_LEVELS = DEF_MAX_LEVELS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_item,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_item,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIDE_W-1:0]    cfg_data
);

    logic      in_accept;
    logic      take;
    unit_pos_t pos;

    // input stage: the item plus its place in the chain
    logic      stage_valid_reg;
    in_item_t  stage_item_reg;
    unit_pos_t stage_pos_reg;

    assign cfg_ready = 1'b1;
    assign in_stall  = stage_valid_reg && !take;
    assign in_accept = in_valid && !in_stall;

    // walk counters, snapshot taken at acceptance
    dxtf_walk #(
        .MAX_SIDE   (MAX_SIDE),
        .MAX_LEVELS (MAX_LEVELS)
    ) u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (in_accept),
        .pos       (pos)
    );

    // an empty stage loads even while the result register is held
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else if (take || !stage_valid_reg)
            stage_valid_reg <= in_accept;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            stage_item_reg <= in_item;
            stage_pos_reg  <= pos;
        end
    end

    // index arithmetic, block row permutation and the result register
    dxtf_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_valid (stage_valid_reg),
        .stage_item  (stage_item_reg),
        .stage_pos   (stage_pos_reg),
        .take        (take),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_item    (out_item)
    );

    // back pressure only when the input stage holds an item it cannot pass on
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> stage_valid_reg && out_valid && out_stall)
        else $error("stall without full pipeline");

    // an accepted item is always in the input stage on the next cycle
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> stage_valid_reg)
        else $error("accepted item lost");

endmodule

/* tb/flip_checker.sv */
`timescale 1ns / 1ps

module flip_checker
    import dxtf_pkg::*;
#(
    parameter int MAX_SIDE   = DEF_MAX_SIDE,
    parameter int MAX_LEVELS = DEF_MAX_LEVELS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  in_item_t             in_item,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  out_item_t            out_item,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIDE_W-1:0]    cfg_data,
    output int unsigned          mismatches,
    output int unsigned          pending,
    output int unsigned          compared
);

    // register copies
    logic [FMT_W-1:0]   fmt_reg;
    logic [SIDE_W-1:0]  width_reg;
    logic [SIDE_W-1:0]  height_reg;
    logic [LEVEL_W-1:0] levels_reg;

    // position of the next unit in the mip walk
    int unsigned        level_idx;
    int unsigned        level_w;
    int unsigned        level_h;
    int unsigned        row_idx;
    int unsigned        col_idx;
    logic [INDEX_W-1:0] level_base;

    out_item_t flipped_q[$];
    out_item_t got;
    out_item_t want;

    function automatic int unsigned clamp_side(input int unsigned v);
        if (v == 0)
            return 1;
        if (v > MAX_SIDE)
            return MAX_SIDE;
        return v;
    endfunction

    // four fields of w bits from bit pos, reversed, first two swapped, or kept
    function automatic logic [63:0] reorder_rows(input logic [63:0] v, input int unsigned pos,
                                                 input int unsigned w, input row_mode_t mode);
        logic [63:0] field_mask;
        logic [63:0] fields [4];
        logic [63:0] res;
        int unsigned src;
        if (mode == ROW_KEEP)
            return v;
        field_mask = (64'd1 << w) - 64'd1;
        for (int i = 0; i < 4; i++)
            fields[i] = (v >> (pos + i * w)) & field_mask;
        res = v;
        for (int i = 0; i < 4; i++)
        begin
            if (mode == ROW_REVERSE)
                src = 3 - i;
            else
                src = (i < 2) ? 1 - i : i;
            res &= ~(field_mask << (pos + i * w));
            res |= fields[src] << (pos + i * w);
        end
        return res;
    endfunction

    task automatic restart_walk();
        level_idx  = 0;
        level_w    = clamp_side(32'(width_reg));
        level_h    = clamp_side(32'(height_reg));
        row_idx    = 0;
        col_idx    = 0;
        level_base = '0;
    endtask

    task automatic flip_unit(input in_item_t u, output out_item_t r);
        int unsigned across;
        int unsigned rows;
        int unsigned levels;
        int unsigned rrow;
        logic        tiled;
        row_mode_t   mode;
        tiled  = fmt_reg < FMT_PIX32;
        across = tiled ? (level_w + 3) >> 2 : level_w;
        rows   = tiled ? (level_h + 3) >> 2 : level_h;
        levels = (levels_reg == 0) ? 1 : 32'(levels_reg);
        if (levels > MAX_LEVELS)
            levels = MAX_LEVELS;
        if (across == 0)
            across = 1;
        if (rows == 0)
            rows = 1;
        if (row_idx >= rows)
            row_idx = rows - 1;
        if (col_idx >= across)
            col_idx = across - 1;
        if (level_h >= 4)
            mode = ROW_REVERSE;
        else if (level_h == 2)
            mode = ROW_SWAP;
        else
            mode = ROW_KEEP;

        rrow = rows - 1 - row_idx;
        r.dest_index   = INDEX_W'(level_base + rrow * across + col_idx);
        r.flipped_high = '0;
        case (fmt_reg)
            FMT_DXT1: r.flipped_low = reorder_rows(u.unit_low, 32, 8, mode);
            FMT_DXT3:
            begin
                r.flipped_low  = reorder_rows(u.unit_low, 0, 16, mode);
                r.flipped_high = reorder_rows(u.unit_high, 32, 8, mode);
            end
            FMT_DXT5:
            begin
                r.flipped_low  = reorder_rows(u.unit_low, 16, 12, mode);
                r.flipped_high = reorder_rows(u.unit_high, 32, 8, mode);
            end
            FMT_PIX32: r.flipped_low = {32'd0, u.unit_low[31:0]};
            FMT_PIX24: r.flipped_low = {40'd0, u.unit_low[23:0]};
            default:   r.flipped_low = {48'd0, u.unit_low[15:0]};
        endcase
        r.chain_end = (level_idx + 1 >= levels) && (row_idx + 1 == rows)
                      && (col_idx + 1 == across);

        col_idx++;
        if (col_idx >= across)
        begin
            col_idx = 0;
            row_idx++;
            if (row_idx >= rows)
            begin
                row_idx    = 0;
                level_base = INDEX_W'(level_base + rows * across);
                level_idx++;
                level_w    = (level_w > 1) ? level_w >> 1 : 1;
                level_h    = (level_h > 1) ? level_h >> 1 : 1;
                if (level_idx >= levels)
                    restart_walk();
            end
        end
    endtask

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 100)
            $display("checker: %s", msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg    = FMT_DXT1;
            width_reg  = SIDE_W'(1);
            height_reg = SIDE_W'(1);
            levels_reg = LEVEL_W'(1);
            restart_walk();
            flipped_q.delete();
            mismatches = 0;
            pending    = 0;
            compared   = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = out_item;
                if (flipped_q.size() == 0)
                    report_mismatch($sformatf("unexpected item, dest_index %h", got.dest_index));
                else
                begin
                    want = flipped_q.pop_front();
                    compared++;
                    if (got.dest_index !== want.dest_index)
                        report_mismatch($sformatf("item %0d dest_index %h, want %h",
                                                  compared, got.dest_index, want.dest_index));
                    if (got.flipped_low !== want.flipped_low)
                        report_mismatch($sformatf("item %0d flipped_low %h, want %h",
                                                  compared, got.flipped_low, want.flipped_low));
                    if (got.flipped_high !== want.flipped_high)
                        report_mismatch($sformatf("item %0d flipped_high %h, want %h",
                                                  compared, got.flipped_high, want.flipped_high));
                    if (got.chain_end !== want.chain_end)
                        report_mismatch($sformatf("item %0d chain_end %b, want %b",
                                                  compared, got.chain_end, want.chain_end));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_FORMAT: fmt_reg    = cfg_data[FMT_W-1:0];
                    CFG_WIDTH:  width_reg  = cfg_data;
                    CFG_HEIGHT: height_reg = cfg_data;
                    CFG_LEVELS: levels_reg = cfg_data[LEVEL_W-1:0];
                endcase
                restart_walk();
            end
            if (in_valid && !in_stall)
            begin
                flip_unit(in_item, want);
                flipped_q.push_back(want);
            end
            pending = flipped_q.size();
        end
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import dxtf_pkg::*;

    // no handshake at all for this long means the block is hung
    localparam int IDLE_LIMIT   = 3000;
    // receiver hold-off, long enough to back the block up into its input
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_UNITS = 1300;
    // most units sent under one random texture setup
    localparam int PHASE_MAX    = 250;

    // format codes without a package name, both decode as two-byte pixels
    localparam logic [FMT_W-1:0] FMT_SPARE6 = 3'd6;
    localparam logic [FMT_W-1:0] FMT_SPARE7 = 3'd7;

    localparam logic [63:0] ALL_ONES  = '1;
    localparam logic [63:0] PAT_UP    = 64'h0123_4567_89ab_cdef;
    localparam logic [63:0] PAT_DOWN  = 64'hfedc_ba98_7654_3210;
    localparam logic [63:0] PAT_FIVES = 64'h5555_5555_5555_5555;
    localparam logic [63:0] PAT_AS    = 64'haaaa_aaaa_aaaa_aaaa;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    in_item_t             in_item;
    logic                 out_valid;
    logic                 out_stall;
    out_item_t            out_item;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SIDE_W-1:0]    cfg_data;

    int unsigned mismatches;
    int unsigned pending;
    int unsigned compared;

    // run state; throttle and hold_req are shared between the sender and the receiver
    bit          throttle;
    bit          hold_req;
    int unsigned units_sent;
    int unsigned setups;
    int unsigned idle_cycles;

    dxt_mip_chain_vertical_flip_top dut (.*);

    // watches all three channels, predicts every item and counts mismatches
    flip_checker u_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // units in a whole chain, used to size well-formed streams
    function automatic int unsigned chain_length(input logic [FMT_W-1:0] fmt,
                                                 input int unsigned w, input int unsigned h,
                                                 input int unsigned lv);
        int unsigned total;
        int unsigned levels;
        int unsigned lw;
        int unsigned lh;
        lw = (w == 0) ? 1 : ((w > DEF_MAX_SIDE) ? DEF_MAX_SIDE : w);
        lh = (h == 0) ? 1 : ((h > DEF_MAX_SIDE) ? DEF_MAX_SIDE : h);
        levels = (lv == 0) ? 1 : lv;
        total = 0;
        for (int k = 0; k < levels; k++)
        begin
            if (fmt < FMT_PIX32)
                total += ((lw + 3) >> 2) * ((lh + 3) >> 2);
            else
                total += lw * lh;
            lw = (lw > 1) ? lw >> 1 : 1;
            lh = (lh > 1) ? lh >> 1 : 1;
        end
        return total;
    endfunction

    // called and returns at a falling edge; valid stays high into the next item
    task automatic push_unit(input logic [63:0] lo, input logic [63:0] hi);
        while (throttle && $urandom_range(99) < 33)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{unit_low: lo, unit_high: hi};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        units_sent++;
    endtask

    // sender stops until every outstanding item has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIDE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // block is idle here; unused upper bits of the narrow registers get noise
    task automatic setup_texture(input logic [FMT_W-1:0] fmt, input int unsigned w,
                                 input int unsigned h, input int unsigned lv);
        logic [SIDE_W-1:0] noise;
        drain_results();
        noise = SIDE_W'($urandom);
        write_reg(CFG_FORMAT, {noise[SIDE_W-1:FMT_W], fmt});
        write_reg(CFG_WIDTH, SIDE_W'(w));
        write_reg(CFG_HEIGHT, SIDE_W'(h));
        write_reg(CFG_LEVELS, {noise[SIDE_W-1:LEVEL_W], LEVEL_W'(lv)});
        cfg_valid <= 1'b0;
        setups++;
    endtask

    // receiver: random stalls, or one long hold-off when asked
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            out_stall <= throttle && ($urandom_range(99) < 33);
        end
    end

    // watchdog: ends the run when no channel moves for too long
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("testbench: no handshake for %0d cycles", IDLE_LIMIT);
        $display("testbench: done, errors");
        $finish;
    end

    initial
    begin
        logic [FMT_W-1:0]   fmt;
        int unsigned        w;
        int unsigned        h;
        int unsigned        lv;
        int unsigned        span;
        int unsigned        count;
        int unsigned        random_sent;
        int unsigned        phase;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_item    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_FORMAT;
        cfg_data   = '0;
        throttle   = 1'b0;
        hold_req   = 1'b0;
        units_sent = 0;
        setups     = 0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings: one-pixel dxt1 chain, every unit ends the chain
        push_unit('0, '0);
        push_unit(ALL_ONES, ALL_ONES);

        // tall enough for a full row reversal, 2x2 blocks
        setup_texture(FMT_DXT1, 8, 8, 1);
        push_unit(PAT_UP, PAT_DOWN);
        push_unit(PAT_DOWN, PAT_UP);
        push_unit(PAT_FIVES, PAT_AS);
        push_unit(PAT_AS, PAT_FIVES);

        // height two swaps the first two rows only
        setup_texture(FMT_DXT3, 4, 2, 1);
        push_unit(PAT_UP, PAT_DOWN);

        // 12-bit alpha index rows reversed, then height three and one left alone
        setup_texture(FMT_DXT5, 4, 4, 1);
        push_unit(PAT_UP, PAT_DOWN);
        setup_texture(FMT_DXT5, 4, 3, 2);
        push_unit(PAT_UP, PAT_DOWN);
        push_unit(PAT_DOWN, PAT_UP);

        // pixel masking, first across a two-level chain
        setup_texture(FMT_PIX32, 2, 2, 2);
        repeat (5) push_unit(ALL_ONES, ALL_ONES);
        setup_texture(FMT_PIX24, 1, 1, 1);
        push_unit(ALL_ONES, ALL_ONES);
        setup_texture(FMT_PIX16, 1, 1, 1);
        push_unit(ALL_ONES, ALL_ONES);

        // unknown format codes fall back to two-byte pixels
        setup_texture(FMT_SPARE6, 1, 1, 1);
        push_unit(ALL_ONES, ALL_ONES);
        setup_texture(FMT_SPARE7, 1, 1, 1);
        push_unit(ALL_ONES, ALL_ONES);

        // zero sizes and zero levels act as one
        setup_texture(FMT_DXT5, 0, 0, 0);
        push_unit(ALL_ONES, ALL_ONES);

        // oversize sides clamp, the first with the most levels
        setup_texture(FMT_PIX16, 32767, 1, 15);
        repeat (3) push_unit(PAT_AS, PAT_FIVES);
        setup_texture(FMT_PIX32, 1, 32767, 1);
        repeat (2) push_unit(PAT_FIVES, PAT_AS);

        // random textures: mostly whole chains, some cut short by the next setup
        random_sent = 0;
        for (phase = 0; random_sent < RANDOM_UNITS; phase++)
        begin
            fmt = FMT_W'($urandom_range(0, 7));
            if ($urandom_range(9) == 0)
            begin
                w  = $urandom_range(0, 32767);
                h  = $urandom_range(0, 32767);
                lv = $urandom_range(0, 15);
            end
            else
            begin
                w  = $urandom_range(0, (fmt < FMT_PIX32) ? 48 : 16);
                h  = $urandom_range(0, (fmt < FMT_PIX32) ? 48 : 16);
                lv = $urandom_range(0, 6);
            end
            setup_texture(fmt, w, h, lv);
            span = chain_length(fmt, w, h, lv);
            if (span <= 400 && $urandom_range(4) != 0)
                count = span * $urandom_range(1, 2) + $urandom_range(0, 2);
            else
                count = $urandom_range(10, 120);
            if (count > PHASE_MAX)
                count = PHASE_MAX;

            // first phase is a long run with no idling on either side
            if (phase == 0 && count < PHASE_MAX)
                count = PHASE_MAX;
            if (phase == 2 && count < 40)
                count = 40;
            // the first four phases always fit, later ones stop at the unit budget
            if (count > RANDOM_UNITS - random_sent)
                count = RANDOM_UNITS - random_sent;
            throttle = (phase >= 2) && ($urandom_range(3) != 0);
            // receiver holds off while the sender keeps offering items
            if (phase == 2)
                hold_req = 1'b1;

            for (int k = 0; k < count; k++)
            begin
                // sender pause until everything has come back
                if ((phase == 3 && k == count / 2) || (phase >= 2 && $urandom_range(299) == 0))
                    drain_results();
                push_unit({$urandom, $urandom}, {$urandom, $urandom});
            end
            random_sent += count;
        end

        drain_results();
        repeat (8) @(negedge clk);

        $display("testbench: %0d units over %0d texture setups, %0d results compared",
                 units_sent, setups, compared);
        $display("testbench: formats 0 to 7, sides 0 to 32767, 0 to 15 levels, %s",
                 "long output hold-off and mid-stream drain");
        if (mismatches == 0 && pending == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
